// ----- hw/rtl/adv_pkg.sv -----
// Shared types, constants and helper functions for the ASCII date validator.
// No dependencies; every other file in hw/rtl refers to this package.
`default_nettype none

package adv_pkg;

  // Payload widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned FAIL_W  = 3;
  localparam int unsigned CFG_W   = YEAR_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FIELD_CHARS = 4;

  // ASCII codes and fixed numbers of the date format
  localparam logic [CHAR_W-1:0] ASCII_HYPHEN = 8'h2D;
  localparam logic [CHAR_W-1:0] ASCII_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] DATE_LEN     = 8'd10;
  localparam logic [6:0]        MONTHS       = 7'd12;
  localparam logic [4:0]        LEAP_FEB_DAYS = 5'd29;

  // Register reset values
  localparam logic [YEAR_W-1:0]  RST_YEAR  = 14'd2000;
  localparam logic [MONTH_W-1:0] RST_MONTH = 4'd1;
  localparam logic [DAY_W-1:0]   RST_DAY   = 5'd1;

  typedef logic [CHAR_W-1:0] char_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURRENT_YEAR  = 2'd0,
    CFG_CURRENT_MONTH = 2'd1,
    CFG_CURRENT_DAY   = 2'd2
  } cfg_idx_t;

  typedef enum logic [FAIL_W-1:0] {
    FAIL_NONE      = 3'd0,
    FAIL_LENGTH    = 3'd1,
    FAIL_SEPARATOR = 3'd2,
    FAIL_YEAR      = 3'd3,
    FAIL_MONTH     = 3'd4,
    FAIL_DAY       = 3'd5,
    FAIL_FUTURE    = 3'd6
  } fail_code_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } cfg_regs_t;

  typedef struct packed {
    char_t [9:0] chars;       // chars[k] is character k of the text
    char_t       text_length;
  } date_item_t;

  // Parsed field: sign, magnitude and the last four decimal digits read
  typedef struct packed {
    logic              neg;
    logic [YEAR_W-1:0] mag;
    logic [3:0]        d3;
    logic [3:0]        d2;
    logic [3:0]        d1;
    logic [3:0]        d0;
  } num_t;

  function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] m);
    logic [4:0] days;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
      4'd2:                                       days = 5'd28;
      default:                                    days = 5'd0;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/adv_ifs.sv -----
// Valid/ready channel interfaces for the date validator: date text in, verdict out.
// Depends on adv_pkg.
`default_nettype none

interface adv_in_if;
  logic           valid;
  logic           ready;
  adv_pkg::char_t byte_0;
  adv_pkg::char_t byte_1;
  adv_pkg::char_t byte_2;
  adv_pkg::char_t byte_3;
  adv_pkg::char_t byte_4;
  adv_pkg::char_t byte_5;
  adv_pkg::char_t byte_6;
  adv_pkg::char_t byte_7;
  adv_pkg::char_t byte_8;
  adv_pkg::char_t byte_9;
  adv_pkg::char_t text_length;

  modport source (output valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5,
                  byte_6, byte_7, byte_8, byte_9, text_length, input ready);
  modport sink   (input valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5,
                  byte_6, byte_7, byte_8, byte_9, text_length, output ready);
endinterface

interface adv_out_if;
  logic                            valid;
  logic                            ready;
  logic                            date_ok;
  logic [adv_pkg::FAIL_W-1:0]      fail_code;

  modport source (output valid, date_ok, fail_code, input ready);
  modport sink   (input valid, date_ok, fail_code, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/adv_atoi.sv -----
// atoi over a four-character window: whitespace skip, optional sign, digits.
// Depends on adv_pkg. Shorter windows are padded with NUL, which ends a number.
`default_nettype none

module adv_atoi (
  input  adv_pkg::char_t [adv_pkg::FIELD_CHARS-1:0] chars_i,  // chars_i[0] first
  output adv_pkg::num_t                             num_o
);

  function automatic logic is_space(input adv_pkg::char_t c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_digit(input adv_pkg::char_t c);
    return (c >= adv_pkg::ASCII_ZERO) && (c <= adv_pkg::ASCII_NINE);
  endfunction

  always_comb begin
    logic           skipping;
    logic           stopped;
    adv_pkg::char_t c;
    adv_pkg::num_t  n;
    skipping = 1'b1;
    stopped  = 1'b0;
    n        = '0;
    for (int i = 0; i < adv_pkg::FIELD_CHARS; i++) begin
      c = chars_i[i];
      if (skipping && is_space(c)) begin
        // still in leading whitespace
      end else if (skipping && ((c == adv_pkg::ASCII_PLUS) || (c == adv_pkg::ASCII_HYPHEN))) begin
        skipping = 1'b0;
        n.neg    = (c == adv_pkg::ASCII_HYPHEN);
      end else if (!stopped && is_digit(c)) begin
        skipping = 1'b0;
        n.mag    = adv_pkg::YEAR_W'(({3'b000, n.mag} << 3) + ({3'b000, n.mag} << 1)
                                    + {13'd0, c[3:0]});
        n.d3     = n.d2;
        n.d2     = n.d1;
        n.d1     = n.d0;
        n.d0     = c[3:0];
      end else begin
        skipping = 1'b0;
        stopped  = 1'b1;
      end
    end
    num_o = n;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/adv_check.sv -----
// Date checks for one registered item: length, separators, ranges, leap year, future.
// Depends on adv_pkg and adv_atoi.
`default_nettype none

module adv_check (
  input  adv_pkg::date_item_t item_i,
  input  adv_pkg::cfg_regs_t  cfg_i,
  output adv_pkg::fail_code_t fail_o
);

  adv_pkg::num_t year_n, month_n, day_n;

  adv_atoi u_year (
    .chars_i ({item_i.chars[3], item_i.chars[2], item_i.chars[1], item_i.chars[0]}),
    .num_o   (year_n)
  );

  adv_atoi u_month (
    .chars_i ({adv_pkg::ASCII_NUL, adv_pkg::ASCII_NUL, item_i.chars[6], item_i.chars[5]}),
    .num_o   (month_n)
  );

  adv_atoi u_day (
    .chars_i ({adv_pkg::ASCII_NUL, adv_pkg::ASCII_NUL, item_i.chars[9], item_i.chars[8]}),
    .num_o   (day_n)
  );

  logic       len_ok, sep_ok, year_ok, month_ok, day_ok, future;
  logic [6:0] mon, day;
  logic       div4, cent, div400, leap;
  logic [4:0] limit;

  // two-digit windows stay below 100
  assign mon = month_n.mag[6:0];
  assign day = day_n.mag[6:0];

  assign len_ok = (item_i.text_length == adv_pkg::DATE_LEN);
  assign sep_ok = (item_i.chars[4] == adv_pkg::ASCII_HYPHEN) &&
                  (item_i.chars[7] == adv_pkg::ASCII_HYPHEN);

  assign year_ok  = !year_n.neg && (year_n.mag != '0) && (year_n.mag <= cfg_i.year);
  assign month_ok = !month_n.neg && (mon != 7'd0) && (mon <= adv_pkg::MONTHS);

  // (10a + b) mod 4 == (2a + b) mod 4, taken on the decimal digits
  assign div4   = (2'({year_n.d1[0], 1'b0}) + year_n.d0[1:0]) == 2'd0;
  assign cent   = (year_n.d1 == 4'd0) && (year_n.d0 == 4'd0);
  assign div400 = cent && ((2'({year_n.d3[0], 1'b0}) + year_n.d2[1:0]) == 2'd0);
  assign leap   = (div4 && !cent) || div400;

  assign limit  = ((mon == 7'd2) && leap) ? adv_pkg::LEAP_FEB_DAYS
                                          : adv_pkg::month_days(mon[3:0]);
  assign day_ok = !day_n.neg && (day != 7'd0) && (day <= {2'b00, limit});

  assign future = (year_n.mag == cfg_i.year) &&
                  ((mon > {3'b000, cfg_i.month}) ||
                   ((mon == {3'b000, cfg_i.month}) && (day > {2'b00, cfg_i.day})));

  always_comb begin
    if (!len_ok)        fail_o = adv_pkg::FAIL_LENGTH;
    else if (!sep_ok)   fail_o = adv_pkg::FAIL_SEPARATOR;
    else if (!year_ok)  fail_o = adv_pkg::FAIL_YEAR;
    else if (!month_ok) fail_o = adv_pkg::FAIL_MONTH;
    else if (!day_ok)   fail_o = adv_pkg::FAIL_DAY;
    else if (future)    fail_o = adv_pkg::FAIL_FUTURE;
    else                fail_o = adv_pkg::FAIL_NONE;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ascii_date_validator_core.sv -----
// Top level of the ASCII yyyy-mm-dd date validator: channels, registers, pipeline.
// Depends on adv_pkg, adv_ifs (adv_in_if, adv_out_if) and adv_check.
//
//  port       | dir | handshake    | carries
//  -----------+-----+--------------+----------------------------------------------
//  in_chan    | in  | valid/ready  | byte_0..byte_9 (date text), text_length
//  out_chan   | out | valid/ready  | date_ok, fail_code (first failing check)
//  cfg_*      | in  | cfg_we only  | cfg_index selects year/month/day, cfg_data
//
// Pipeline: one transaction per clock while out_chan.ready is high; input register
//   then result register, with all checks in the logic between.
// Reset: rst_n synchronous, active low; empties both stages and loads today's
//   date registers with 2000-01-01.
// Stalls: out_chan.ready low holds the result; the input register still takes
//   one more transaction, and in_chan.ready drops only when both stages are full.
`default_nettype none

module ascii_date_validator_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  adv_in_if.sink                             in_chan,
  adv_out_if.source                          out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [adv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [adv_pkg::CFG_W-1:0]     cfg_data
);

  // Configuration registers: today's date
  adv_pkg::cfg_regs_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        adv_pkg::CFG_CURRENT_YEAR:  cfg_nxt.year  = cfg_data[adv_pkg::YEAR_W-1:0];
        adv_pkg::CFG_CURRENT_MONTH: cfg_nxt.month = cfg_data[adv_pkg::MONTH_W-1:0];
        adv_pkg::CFG_CURRENT_DAY:   cfg_nxt.day   = cfg_data[adv_pkg::DAY_W-1:0];
        default:                    cfg_nxt = cfg_r;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.year  <= adv_pkg::RST_YEAR;
      cfg_r.month <= adv_pkg::RST_MONTH;
      cfg_r.day   <= adv_pkg::RST_DAY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Pipeline control
  logic in_v_r, in_v_nxt;
  logic out_v_r, out_v_nxt;
  logic advance;     // input stage moves into the result stage
  logic in_xfer;     // input transaction this cycle

  assign advance       = !out_v_r || out_chan.ready;
  assign in_chan.ready = !in_v_r || advance;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  always_comb begin
    in_v_nxt  = in_v_r;
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = in_v_r;
      in_v_nxt  = 1'b0;
    end
    if (in_xfer) in_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Input register
  adv_pkg::date_item_t item_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.chars <= {in_chan.byte_9, in_chan.byte_8, in_chan.byte_7, in_chan.byte_6,
                       in_chan.byte_5, in_chan.byte_4, in_chan.byte_3, in_chan.byte_2,
                       in_chan.byte_1, in_chan.byte_0};
      item_r.text_length <= in_chan.text_length;
    end
  end

  // Checks
  adv_pkg::fail_code_t fail_nxt;

  adv_check u_check (
    .item_i (item_r),
    .cfg_i  (cfg_r),
    .fail_o (fail_nxt)
  );

  // Result register
  adv_pkg::fail_code_t fail_r;

  always_ff @(posedge clk) begin
    if (advance && in_v_r) fail_r <= fail_nxt;
  end

  assign out_chan.valid     = out_v_r;
  assign out_chan.fail_code = fail_r;
  assign out_chan.date_ok   = (fail_r == adv_pkg::FAIL_NONE);

  // Assertions
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (in_v_r && out_v_r))
    else $error("input stalled while a pipeline stage is empty");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_v_r)
    else $error("accepted transaction missing from input register");

  a_length_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && (item_r.text_length != adv_pkg::DATE_LEN)) |->
      (fail_nxt == adv_pkg::FAIL_LENGTH))
    else $error("bad length not reported as length failure");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && advance) |=> out_v_r)
    else $error("input stage item lost on advance");

endmodule

`default_nettype wire

// ----- test/tb_ascii_date_validator_core.sv -----
// Self-checking testbench for ascii_date_validator_core: yyyy-mm-dd text in, verdict out.
// Depends on adv_pkg and the adv_in_if / adv_out_if channel interfaces from hw/rtl.
// A behavioral date checker predicts every verdict; a scoreboard compares them in order.
`default_nettype none

module tb_ascii_date_validator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import adv_pkg::*;

  // Characters that the field parser treats specially, beyond those in adv_pkg
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_CR    = 8'h0D;

  // Generous: ~1350 transactions, each at worst a long gap on both sides
  localparam int CYCLE_LIMIT = 200_000;

  bit   clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  adv_in_if  in_chan ();
  adv_out_if out_chan ();

  ascii_date_validator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Testbench copy of today's date registers; only changed while the block is idle
  logic [YEAR_W-1:0]  today_year;
  logic [MONTH_W-1:0] today_month;
  logic [DAY_W-1:0]   today_day;

  fail_code_t verdict_q[$];   // expected verdicts, oldest first
  int         mismatch_count;
  int         cycle_count;
  bit         calm;           // when set, neither side inserts bubbles

  // ---------------------------------------------------------------------------
  // Date checker
  // ---------------------------------------------------------------------------

  function automatic bit is_blank(char_t c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // atoi over an n-character window: blanks, one optional sign, then digits
  function automatic int field_value(date_item_t d, int first, int n);
    int i = 0;
    int val = 0;
    bit neg = 1'b0;
    while (i < n && is_blank(d.chars[first + i])) i++;
    if (i < n && (d.chars[first + i] == ASCII_PLUS || d.chars[first + i] == ASCII_HYPHEN)) begin
      neg = (d.chars[first + i] == ASCII_HYPHEN);
      i++;
    end
    while (i < n && d.chars[first + i] >= ASCII_ZERO && d.chars[first + i] <= ASCII_NINE) begin
      val = val * 10 + int'(d.chars[first + i] - ASCII_ZERO);
      i++;
    end
    return neg ? -val : val;
  endfunction

  // First failing check wins: length, separators, year, month, day, future
  function automatic fail_code_t judge_date(date_item_t d);
    int yr, mo, dy, last_day;
    int cy = int'(today_year);
    int cm = int'(today_month);
    int cd = int'(today_day);
    if (d.text_length != DATE_LEN) return FAIL_LENGTH;
    if (d.chars[4] != ASCII_HYPHEN || d.chars[7] != ASCII_HYPHEN) return FAIL_SEPARATOR;
    yr = field_value(d, 0, 4);
    mo = field_value(d, 5, 2);
    dy = field_value(d, 8, 2);
    if (yr <= 0 || yr > cy) return FAIL_YEAR;
    if (mo <= 0 || mo > int'(MONTHS)) return FAIL_MONTH;
    case (mo)
      4, 6, 9, 11: last_day = 30;
      2: last_day = ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0) ?
                    int'(LEAP_FEB_DAYS) : 28;
      default: last_day = 31;
    endcase
    if (dy <= 0 || dy > last_day) return FAIL_DAY;
    if (yr == cy && (mo > cm || (mo == cm && dy > cd))) return FAIL_FUTURE;
    return FAIL_NONE;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  function automatic date_item_t text_item(string s);
    date_item_t d;
    for (int k = 0; k < 10; k++) d.chars[k] = s[k];
    d.text_length = DATE_LEN;
    return d;
  endfunction

  // Well-formed zero-padded date; each field is taken modulo ten to the power of its digit count
  function automatic date_item_t spell_date(int y, int m, int dd);
    date_item_t d;
    d.chars[0] = ASCII_ZERO + char_t'((y / 1000) % 10);
    d.chars[1] = ASCII_ZERO + char_t'((y / 100) % 10);
    d.chars[2] = ASCII_ZERO + char_t'((y / 10) % 10);
    d.chars[3] = ASCII_ZERO + char_t'(y % 10);
    d.chars[4] = ASCII_HYPHEN;
    d.chars[5] = ASCII_ZERO + char_t'((m / 10) % 10);
    d.chars[6] = ASCII_ZERO + char_t'(m % 10);
    d.chars[7] = ASCII_HYPHEN;
    d.chars[8] = ASCII_ZERO + char_t'((dd / 10) % 10);
    d.chars[9] = ASCII_ZERO + char_t'(dd % 10);
    d.text_length = DATE_LEN;
    return d;
  endfunction

  // Blank, sign or arbitrary byte: the characters that bend the parser
  function automatic char_t odd_char();
    case ($urandom_range(4))
      0: return CH_SPACE;
      1: return char_t'($urandom_range(CH_CR, CH_TAB));
      2: return ASCII_PLUS;
      3: return ASCII_HYPHEN;
      default: return char_t'($urandom);
    endcase
  endfunction

  // Mostly well-formed dates clustered around today and the month ends,
  // with a minority bent by blanks, signs, bad separators or bad lengths
  function automatic date_item_t shaped_date();
    date_item_t d;
    int y, m, dd, pick;
    int cy = int'(today_year);
    pick = $urandom_range(99);
    if (pick < 35)      y = cy;
    else if (pick < 65) y = $urandom_range(cy > 0 ? cy : 1, 1);
    else if (pick < 80) y = $urandom_range(9999);
    else if (pick < 90) y = 4 * $urandom_range(2499);
    else                y = 100 * $urandom_range(99);
    pick = $urandom_range(99);
    if (pick < 25)      m = int'(today_month);
    else if (pick < 45) m = 2;
    else if (pick < 90) m = $urandom_range(12, 1);
    else                m = $urandom_range(99);
    pick = $urandom_range(99);
    if (pick < 25)      dd = int'(today_day);
    else if (pick < 50) dd = $urandom_range(31, 27);
    else if (pick < 90) dd = $urandom_range(31, 1);
    else                dd = $urandom_range(99);
    d = spell_date(y, m, dd);
    pick = $urandom_range(99);
    if (pick < 10)      d.chars[$urandom_range(9)] = odd_char();
    else if (pick < 14) d.text_length = char_t'($urandom_range(255));
    else if (pick < 18) d.chars[$urandom_range(1) ? 4 : 7] = odd_char();
    else if (pick < 28) begin
      // leading blank, sign or arbitrary byte at the head of one field
      case ($urandom_range(2))
        0: d.chars[0] = odd_char();
        1: d.chars[5] = odd_char();
        default: d.chars[8] = odd_char();
      endcase
    end
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel and register drivers (all changes at the falling edge)
  // ---------------------------------------------------------------------------

  // Offer one transaction and hold it until taken; leaves valid high on return
  task automatic send_date(input date_item_t d);
    while (!calm && $urandom_range(99) < 11) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.byte_0      <= d.chars[0];
    in_chan.byte_1      <= d.chars[1];
    in_chan.byte_2      <= d.chars[2];
    in_chan.byte_3      <= d.chars[3];
    in_chan.byte_4      <= d.chars[4];
    in_chan.byte_5      <= d.chars[5];
    in_chan.byte_6      <= d.chars[6];
    in_chan.byte_7      <= d.chars[7];
    in_chan.byte_8      <= d.chars[8];
    in_chan.byte_9      <= d.chars[9];
    in_chan.text_length <= d.text_length;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // Stop offering and wait until every verdict is back, plus pipeline slack
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Load today's date, one register per cycle; month and day get junk upper bits
  task automatic set_today(int y, int m, int dd);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CURRENT_YEAR;
    cfg_data  <= CFG_W'(y);
    @(negedge clk);
    cfg_index <= CFG_CURRENT_MONTH;
    cfg_data  <= (CFG_W'($urandom) & ~CFG_W'(4'hF)) | CFG_W'(m);
    @(negedge clk);
    cfg_index <= CFG_CURRENT_DAY;
    cfg_data  <= (CFG_W'($urandom) & ~CFG_W'(5'h1F)) | CFG_W'(dd);
    @(negedge clk);
    cfg_we      <= 1'b0;
    today_year  = YEAR_W'(y);
    today_month = MONTH_W'(m);
    today_day   = DAY_W'(dd);
  endtask

  // Receiver back-pressure, off while calm
  always @(negedge clk) out_chan.ready <= calm || ($urandom_range(99) >= 11);

  // ---------------------------------------------------------------------------
  // Scoreboard: predicts at input acceptance, checks at output acceptance
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : scoreboard
    date_item_t seen;
    fail_code_t want;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (verdict_q.size() == 0) begin
          $error("fail_code: expected no transaction, got date_ok=%0b fail_code=%0d",
                 out_chan.date_ok, out_chan.fail_code);
          mismatch_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_chan.date_ok !== (want == FAIL_NONE)) begin
            $error("date_ok: expected %0b, got %0b", want == FAIL_NONE, out_chan.date_ok);
            mismatch_count++;
          end
          if (out_chan.fail_code !== want) begin
            $error("fail_code: expected %0d, got %0d", want, out_chan.fail_code);
            mismatch_count++;
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        seen.chars[0]    = in_chan.byte_0;
        seen.chars[1]    = in_chan.byte_1;
        seen.chars[2]    = in_chan.byte_2;
        seen.chars[3]    = in_chan.byte_3;
        seen.chars[4]    = in_chan.byte_4;
        seen.chars[5]    = in_chan.byte_5;
        seen.chars[6]    = in_chan.byte_6;
        seen.chars[7]    = in_chan.byte_7;
        seen.chars[8]    = in_chan.byte_8;
        seen.chars[9]    = in_chan.byte_9;
        seen.text_length = in_chan.text_length;
        verdict_q.push_back(judge_date(seen));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset date 2000-01-01: every check, parser corner and leap rule by hand
  task automatic test_directed_cases();
    date_item_t d;
    send_date(text_item("1999-12-31"));
    send_date(text_item("2000-01-01"));        // exactly today
    send_date(text_item("2000-01-02"));        // one day ahead
    send_date(text_item("2000-02-01"));        // one month ahead
    d = text_item("1999-12-31"); d.text_length = 8'd0;   send_date(d);
    d = text_item("1999-12-31"); d.text_length = 8'd255; send_date(d);
    d = text_item("1999-12-31"); d.text_length = 8'd9;   send_date(d);
    send_date(text_item("1999/12-31"));
    d = text_item("1999-12-31"); d.chars[7] = ASCII_NUL; send_date(d);
    send_date(text_item("0000-01-01"));
    send_date(text_item("2001-01-01"));
    send_date(text_item("-001-01-01"));        // negative year
    send_date(text_item("+999-01-01"));        // plus sign then digits
    send_date(text_item("  12-06-15"));        // leading blanks in the year
    send_date(text_item("1999-00-10"));
    send_date(text_item("1999-13-10"));
    send_date(text_item("1999-+ -01"));        // sign with no digits reads zero
    send_date(text_item("1999- 9-\t7"));
    send_date(text_item("1999-04-31"));
    send_date(text_item("1999-04-00"));
    send_date(text_item("1999-05-  "));        // all-blank day reads zero
    send_date(text_item("1999-01-32"));
    send_date(text_item("1996-02-29"));        // plain leap year
    send_date(text_item("1900-02-29"));        // century, not leap
    send_date(text_item("1600-02-29"));        // fourth century, leap
    send_date(text_item("1999-02-29"));
    // NUL and 0xFF end a number like any other non-digit
    d = text_item("1999-1x-31");
    d.chars[2] = ASCII_NUL;
    d.chars[3] = 8'hFF;
    d.chars[9] = CH_CR;
    send_date(d);
  endtask

  // Today at the ends of the date range in every register, including values outside that range
  task automatic test_today_extremes();
    set_today(9999, 12, 31);
    send_date(spell_date(9999, 12, 31));
    repeat (150) send_date(shaped_date());
    set_today(1, 1, 1);
    send_date(spell_date(1, 1, 1));
    send_date(spell_date(1, 1, 2));
    repeat (80) send_date(shaped_date());
    set_today(0, 12, 31);                      // no year can pass
    repeat (50) send_date(shaped_date());
    set_today(2024, 0, 0);                     // every 2024 date is in the future
    repeat (60) send_date(shaped_date());
    set_today(2024, 15, 31);                   // month beyond 12 never limits
    repeat (60) send_date(shaped_date());
  endtask

  // February around day 29 across the three leap rules
  task automatic test_leap_february();
    int y, pick;
    set_today(9999, 12, 31);
    repeat (150) begin
      pick = $urandom_range(9);
      if (pick < 3)      y = 400 * $urandom_range(24, 1);
      else if (pick < 6) y = 100 * $urandom_range(99, 1);
      else if (pick < 9) y = 4 * $urandom_range(2499, 1);
      else               y = $urandom_range(9999, 1);
      send_date(spell_date(y, ($urandom_range(9) == 0) ? $urandom_range(12, 1) : 2,
                           $urandom_range(30, 27)));
    end
  endtask

  // Random today, shaped dates; the first phase runs back to back with no bubbles
  task automatic test_random_dates();
    for (int p = 0; p < 4; p++) begin
      set_today($urandom_range(9999, 1), $urandom_range(12, 1), $urandom_range(31, 1));
      calm = (p == 0);
      repeat (150) send_date(shaped_date());
    end
    calm = 1'b0;
  endtask

  // Arbitrary bytes; half keep the length and, independently, half keep the separators so the parser still sees them
  task automatic test_byte_noise();
    date_item_t d;
    set_today($urandom_range(9999, 1), $urandom_range(12, 1), $urandom_range(31, 1));
    repeat (150) begin
      for (int k = 0; k < 10; k++) d.chars[k] = char_t'($urandom);
      d.text_length = $urandom_range(1) ? DATE_LEN : char_t'($urandom_range(255));
      if ($urandom_range(1)) begin
        d.chars[4] = ASCII_HYPHEN;
        d.chars[7] = ASCII_HYPHEN;
      end
      send_date(d);
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_CURRENT_YEAR;
    cfg_data            = '0;
    in_chan.valid       = 1'b0;
    in_chan.byte_0      = '0;
    in_chan.byte_1      = '0;
    in_chan.byte_2      = '0;
    in_chan.byte_3      = '0;
    in_chan.byte_4      = '0;
    in_chan.byte_5      = '0;
    in_chan.byte_6      = '0;
    in_chan.byte_7      = '0;
    in_chan.byte_8      = '0;
    in_chan.byte_9      = '0;
    in_chan.text_length = '0;
    out_chan.ready      = 1'b1;
    today_year          = RST_YEAR;
    today_month         = RST_MONTH;
    today_day           = RST_DAY;
    mismatch_count      = 0;
    cycle_count         = 0;
    calm                = 1'b0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_today_extremes();
    test_leap_february();
    test_random_dates();
    test_byte_noise();

    // All verdicts back; the extra wait after draining catches any stray transaction
    drain_results();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
